@@ src/contiguous_hole_allocator_core_defines.svh @@
// assertion macros used by the checker file
`ifndef CONTIGUOUS_HOLE_ALLOCATOR_CORE_DEFINES_SVH
`define CONTIGUOUS_HOLE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define CHA_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hole allocator check failed");

// next-cycle implication
`define CHA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hole allocator check failed");

`endif

@@ src/cha_pkg.sv @@
package cha_pkg;

	localparam int ADDR_BITS = 16;
	// merged length before saturation: block plus up to two holes
	localparam int LEN_BITS  = ADDR_BITS + 2;
	localparam int SUM_BITS  = LEN_BITS + 1;
	localparam int MAX_MERGES = 2;

	localparam logic [ADDR_BITS-1:0] ADDR_MASK      = {ADDR_BITS{1'b1}};
	localparam logic [ADDR_BITS-1:0] MEM_SIZE_RESET = 16'hFFFF;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic [0:0] REG_FIT_METHOD = 1'b0;
	localparam logic [0:0] REG_MEM_SIZE   = 1'b1;

	localparam logic [1:0] MODE_PICK  = 2'd0;
	localparam logic [1:0] MODE_MERGE = 2'd1;
	localparam logic [1:0] MODE_SHIFT = 2'd2;

	typedef struct packed {
		logic                 command;
		logic [ADDR_BITS-1:0] block_size;
		logic [ADDR_BITS-1:0] start_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] granted_address;
		logic [1:0]           status;
		logic [ADDR_BITS-1:0] merged_start;
		logic [ADDR_BITS-1:0] merged_size;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic       start;
		logic [1:0] mode;
		logic       finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pass_idle;
		logic is_release;
		logic need_zero;
		logic pick_ok;
		logic pick_exact;
	} ctrl_status_t;

endpackage

@@ src/contiguous_hole_allocator_core.sv @@
// Free-hole table allocator over a 1-based address space.
// req channel (valid/ready) carries command, block_size and start_address;
// rsp channel (valid/ready) returns granted_address, status and the merged
// hole for every request beat. cfg_write with cfg_index/cfg_data sets
// fit_method (0 first, 1 best, 2 worst fit) or the managed size; writing
// the size reseeds the table with the single hole {1, size}, or none for 0.
// One request is worked at a time. Each allocate or release reads the hole
// table once, one entry per cycle through the table RAM read port; a release
// of size zero skips the read. An exact-fit allocate adds a second pass over
// the entries behind the chosen hole to close the gap.
// Reset clears nothing in the table RAM: the hole count becomes one and
// entry 0 reads as {1, 65535} until first written, so requests are taken
// right after reset. A result sits in the output register until taken;
// while it waits the next request is accepted and worked, and its result is
// held back until the output register frees.
module contiguous_hole_allocator_core #(
	parameter int MAX_HOLES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [0:0]                    cfg_index,
	input  logic [cha_pkg::ADDR_BITS-1:0] cfg_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  cha_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output cha_pkg::rsp_t                 rsp
);

	cha_pkg::ctrl_cmd_t    cmd;
	cha_pkg::ctrl_status_t stat;

	cha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	cha_dpath #(
		.MAX_HOLES (MAX_HOLES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

@@ src/cha_ram.sv @@
module cha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/cha_ctrl.sv @@
module cha_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  cha_pkg::ctrl_status_t stat,
	output cha_pkg::ctrl_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_PICK   = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_MERGE  = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       slot_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.start  = 1'b0;
		cmd.mode   = cha_pkg::MODE_PICK;
		cmd.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (!stat.is_release) begin
					cmd.start = 1'b1;
					cmd.mode  = cha_pkg::MODE_PICK;
					state_d   = S_PICK;
				end else if (stat.need_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.start = 1'b1;
					cmd.mode  = cha_pkg::MODE_MERGE;
					state_d   = S_MERGE;
				end
			end
			S_PICK: begin
				if (stat.pass_idle) begin
					// exact fit: close the gap left by the removed hole
					if (stat.pick_ok && stat.pick_exact) begin
						cmd.start = 1'b1;
						cmd.mode  = cha_pkg::MODE_SHIFT;
						state_d   = S_SHIFT;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SHIFT, S_MERGE: begin
				if (stat.pass_idle) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/cha_dpath.sv @@
module cha_dpath #(
	parameter int MAX_HOLES = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [0:0]                      cfg_index,
	input  logic [cha_pkg::ADDR_BITS-1:0]   cfg_data,
	input  cha_pkg::req_t                   req,
	input  cha_pkg::ctrl_cmd_t              cmd,
	output cha_pkg::ctrl_status_t           stat,
	output cha_pkg::rsp_t                   rsp
);

	localparam int AW = cha_pkg::ADDR_BITS;
	localparam int LW = cha_pkg::LEN_BITS;
	localparam int SW = cha_pkg::SUM_BITS;
	localparam int IW = $clog2(MAX_HOLES);
	localparam int CW = $clog2(MAX_HOLES + 1);
	localparam int EW = 2 * AW;

	// configuration and table bookkeeping
	logic [1:0]    fit_q;
	logic [AW-1:0] msize_q;
	logic [CW-1:0] count_q;
	logic          seed_q;

	// current request
	logic          is_rel_q;
	logic [AW-1:0] need_q;
	logic [AW-1:0] addr_q;

	// table pass
	logic          rd_act_q;
	logic [CW-1:0] rd_ptr_q;
	logic [1:0]    mode_q;
	logic          ev_valid_s1;
	logic [IW-1:0] ev_idx_s1;
	logic          ev_seed_s1;

	// hole choice
	logic          found_q;
	logic [IW-1:0] sel_idx_q;
	logic [AW-1:0] sel_start_q;
	logic [AW-1:0] sel_len_q;

	// release merge
	logic [AW-1:0] ns_q;
	logic [LW-1:0] nl_q;
	logic [1:0]    drops_q;

	cha_pkg::rsp_t rsp_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [EW-1:0] ram_rdata;

	logic [AW-1:0] ent_start, ent_len;
	logic          take;
	logic          ge, lt, eq, gt;
	logic [SW-1:0] up_sum;
	logic [AW:0]   dn_sum;
	logic          up_hit, dn_hit, can_merge, drop;
	logic          pass_wr;
	logic [CW-1:0] begin_idx;
	logic [CW-1:0] cnt_after;
	logic          full, pick_ok, pick_exact, rel_ok;
	logic [AW-1:0] sat_len, split_len, split_addr;
	cha_pkg::rsp_t rsp_d;

	cha_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_HOLES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_act_q),
		.raddr (rd_ptr_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// entry 0 reads as the seed hole until it is first written
	assign ent_start = ev_seed_s1 ? AW'(1) : ram_rdata[EW-1:AW];
	assign ent_len   = ev_seed_s1 ? msize_q : ram_rdata[AW-1:0];

	assign ge = (ent_len >= need_q);
	assign lt = (ent_len < sel_len_q);
	assign eq = (ent_len == sel_len_q);
	assign gt = (ent_len > sel_len_q);

	always_comb begin
		case (fit_q)
			cha_pkg::FIT_BEST: begin
				take = ge && (!found_q || lt || (eq && (ent_start < sel_start_q)));
			end
			cha_pkg::FIT_WORST: begin
				take = !found_q || gt || (eq && (ent_start > sel_start_q));
			end
			default: begin
				take = ge && !found_q;
			end
		endcase
		take = take && ev_valid_s1 && (mode_q == cha_pkg::MODE_PICK);
	end

	assign up_sum    = SW'(ns_q) + SW'(nl_q);
	assign dn_sum    = (AW + 1)'(ent_start) + (AW + 1)'(ent_len);
	assign up_hit    = (SW'(ent_start) == up_sum);
	assign dn_hit    = (dn_sum == (AW + 1)'(ns_q));
	assign can_merge = (mode_q == cha_pkg::MODE_MERGE) && (drops_q != 2'(cha_pkg::MAX_MERGES));
	assign drop      = ev_valid_s1 && can_merge && (up_hit || dn_hit);

	// kept entries slide down over the dropped ones
	assign pass_wr = ev_valid_s1 && (mode_q != cha_pkg::MODE_PICK) && !drop && (drops_q != 2'd0);

	assign cnt_after  = count_q - CW'(drops_q);
	assign full       = (cnt_after >= CW'(MAX_HOLES));
	assign pick_ok    = found_q && (sel_len_q >= need_q) && (need_q != '0);
	assign pick_exact = (sel_len_q == need_q);
	assign rel_ok     = is_rel_q && (need_q != '0) && !full;
	assign sat_len    = (nl_q > LW'(cha_pkg::ADDR_MASK)) ? cha_pkg::ADDR_MASK : nl_q[AW-1:0];
	assign split_len  = sel_len_q - need_q;
	assign split_addr = sel_start_q + split_len;

	assign begin_idx = (cmd.mode == cha_pkg::MODE_SHIFT) ? (CW'(sel_idx_q) + CW'(1)) : '0;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ev_idx_s1 - IW'(drops_q);
		ram_wdata = {ent_start, ent_len};
		if (pass_wr) begin
			ram_we = 1'b1;
		end else if (cmd.finish) begin
			if (!is_rel_q && pick_ok && !pick_exact) begin
				ram_we    = 1'b1;
				ram_waddr = sel_idx_q;
				ram_wdata = {sel_start_q, split_len};
			end else if (rel_ok) begin
				ram_we    = 1'b1;
				ram_waddr = cnt_after[IW-1:0];
				ram_wdata = {ns_q, sat_len};
			end
		end
	end

	always_comb begin
		rsp_d                 = '0;
		rsp_d.status          = cha_pkg::ST_DONE;
		if (!is_rel_q) begin
			if (!pick_ok) begin
				rsp_d.status = cha_pkg::ST_NO_FIT;
			end else if (pick_exact) begin
				rsp_d.granted_address = sel_start_q;
			end else begin
				rsp_d.granted_address = split_addr;
			end
		end else if (need_q != '0) begin
			if (full) begin
				rsp_d.status = cha_pkg::ST_FULL;
			end else begin
				rsp_d.merged_start = ns_q;
				rsp_d.merged_size  = sat_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q       <= cha_pkg::FIT_FIRST;
			msize_q     <= cha_pkg::MEM_SIZE_RESET;
			count_q     <= CW'(1);
			seed_q      <= 1'b1;
			rd_act_q    <= 1'b0;
			rd_ptr_q    <= '0;
			mode_q      <= cha_pkg::MODE_PICK;
			ev_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			drops_q     <= 2'd0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					cha_pkg::REG_FIT_METHOD: begin
						fit_q <= cfg_data[1:0];
					end
					cha_pkg::REG_MEM_SIZE: begin
						msize_q <= cfg_data;
						seed_q  <= 1'b1;
						count_q <= (cfg_data != '0) ? CW'(1) : '0;
					end
				endcase
			end else begin
				if (ram_we && (ram_waddr == '0)) begin
					seed_q <= 1'b0;
				end
				if (cmd.finish) begin
					if (!is_rel_q && pick_ok && pick_exact) begin
						count_q <= count_q - CW'(1);
					end else if (rel_ok) begin
						count_q <= cnt_after + CW'(1);
					end
				end
			end

			if (cmd.start) begin
				mode_q   <= cmd.mode;
				rd_ptr_q <= begin_idx;
				rd_act_q <= (begin_idx < count_q);
			end else if (rd_act_q) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
				rd_act_q <= ((rd_ptr_q + CW'(1)) < count_q);
			end
			ev_valid_s1 <= rd_act_q;

			if (cmd.start && (cmd.mode == cha_pkg::MODE_PICK)) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end

			if (cmd.start) begin
				drops_q <= (cmd.mode == cha_pkg::MODE_SHIFT) ? 2'd1 : 2'd0;
			end else if (drop) begin
				drops_q <= drops_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ev_idx_s1  <= rd_ptr_q[IW-1:0];
		ev_seed_s1 <= seed_q && (rd_ptr_q == '0);
		if (cmd.load) begin
			is_rel_q <= (req.command == cha_pkg::CMD_RELEASE);
			need_q   <= req.block_size;
			addr_q   <= req.start_address;
		end
		if (take) begin
			sel_idx_q   <= ev_idx_s1;
			sel_start_q <= ent_start;
			sel_len_q   <= ent_len;
		end
		if (cmd.start && (cmd.mode == cha_pkg::MODE_MERGE)) begin
			ns_q <= addr_q;
			nl_q <= LW'(need_q);
		end else if (drop) begin
			if (!up_hit) begin
				ns_q <= ent_start;
			end
			nl_q <= nl_q + LW'(ent_len);
		end
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

	assign stat.pass_idle  = !rd_act_q && !ev_valid_s1;
	assign stat.is_release = is_rel_q;
	assign stat.need_zero  = (need_q == '0);
	assign stat.pick_ok    = pick_ok;
	assign stat.pick_exact = pick_exact;

endmodule

@@ src/cha_checker.sv @@
`include "contiguous_hole_allocator_core_defines.svh"

module cha_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input cha_pkg::rsp_t rsp
);

	// a stalled result beat keeps its payload
	`CHA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// one request at a time: no accept in the cycle after an accept
	`CHA_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)

	`CHA_ASSERT_SAME(a_status_code, clk, arst_n, rsp_valid, (rsp.status == cha_pkg::ST_DONE) || (rsp.status == cha_pkg::ST_NO_FIT) || (rsp.status == cha_pkg::ST_FULL))

	// a grant is a successful allocate and never reports a merged hole
	`CHA_ASSERT_SAME(a_grant_alone, clk, arst_n, rsp_valid && (rsp.granted_address != '0), (rsp.status == cha_pkg::ST_DONE) && (rsp.merged_start == '0) && (rsp.merged_size == '0))

endmodule

bind contiguous_hole_allocator_core cha_checker u_cha_checker (.*);
